// File: rtl/core/hrp_pkg.sv
// Shared types and constants for the heightmap ray pick block.
// No dependencies; imported by the top module, the multiplier and the divider.
`timescale 1ns / 1ps

package hrp_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int SIDE_W     = 6;
  localparam int TOP_LEVEL  = 20;
  localparam int LVL_W      = 5;
  localparam int PLANE_STEP = 16384;  // 0.25 in Q16.16
  localparam int CFG_W      = 7;
  localparam int COORD_W    = 32;
  localparam int DIR_W      = 18;
  localparam int RISE_W     = 34;
  localparam int OPB_W      = DIR_W + 1;
  localparam int PROD_W     = RISE_W + OPB_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = DIR_W + 16;
  localparam int QUO_W      = SIDE_W + 1;
  localparam int STEP_W     = 3;
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [0:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_PICK = 1'b1
  } op_e;

  typedef struct packed {
    logic                     start;
    logic signed [NUM_W-1:0]  dividend;
    logic [DEN_W-1:0]         divisor;
  } div_ctl_t;

  typedef struct packed {
    logic              done;
    logic              out_of_range;
    logic [SIDE_W-1:0] quotient;
  } div_sts_t;

endpackage

// File: rtl/core/heightmap_ray_pick.sv
// A pick runs its setup steps, then tries levels 20 down to 0 in turn until a tile
// matches; a flat ray (dy of zero) skips the search and answers with no hit.
// A load word is written to the store when accepted. One word at a time: s_axis_tready
// is high only while idle; the multiplier serves all products, the divider both axes.
// Reset (rst_ni, async, active low) sets both map sizes to 64 and idles the sequencer;
// heightmap contents are undefined until loaded.
`timescale 1ns / 1ps

module heightmap_ray_pick (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hrp_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tile_x, tile_z, tile_level, cam_x, cam_y, cam_z, dir_x, dir_y, dir_z, zero fill
  input  logic [hrp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // operation
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit, hit_x, hit_z, hit_level, zero fill
  output logic [hrp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import hrp_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PRE0 = 12'b000000000010,
    S_PRE1 = 12'b000000000100,
    S_PRE2 = 12'b000000001000,
    S_LV0  = 12'b000000010000,
    S_LV1  = 12'b000000100000,
    S_LV2  = 12'b000001000000,
    S_DIVX = 12'b000010000000,
    S_DIVZ = 12'b000100000000,
    S_RD   = 12'b001000000000,
    S_CMP  = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Input word fields.
  logic [SIDE_W-1:0]        in_tx, in_tz;
  logic [7:0]               in_lvl;
  logic signed [COORD_W-1:0] in_cx, in_cy, in_cz;
  logic signed [DIR_W-1:0]  in_dx, in_dy, in_dz;

  assign in_tx  = s_axis_tdata[5:0];
  assign in_tz  = s_axis_tdata[11:6];
  assign in_lvl = s_axis_tdata[19:12];
  assign in_cx  = s_axis_tdata[51:20];
  assign in_cy  = s_axis_tdata[83:52];
  assign in_cz  = s_axis_tdata[115:84];
  assign in_dx  = s_axis_tdata[133:116];
  assign in_dy  = s_axis_tdata[151:134];
  assign in_dz  = s_axis_tdata[169:152];

  // Configuration.
  logic [CFG_W-1:0] map_w_q, map_h_q;
  logic [CFG_W-1:0] w_eff, h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= CFG_W'(MAX_SIDE);
      map_h_q <= CFG_W'(MAX_SIDE);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_WIDTH:  map_w_q <= cfg_data_i;
        CFG_MAP_HEIGHT: map_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp oversized map registers to the store side.
  assign w_eff = (map_w_q > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : map_w_q;
  assign h_eff = (map_h_q > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : map_h_q;

  // Pick operands, held for the whole search, and the search state.
  logic signed [COORD_W-1:0] cx_q, cz_q;
  logic signed [DIR_W-1:0]   dx_q, dz_q;
  logic [DIR_W-1:0]          absdy_q;
  logic                      dyneg_q;
  logic signed [RISE_W-1:0]  srise_q, srise_d;
  logic signed [PROD_W-1:0]  accx_q, accz_q;
  logic signed [NUM_W-1:0]   nx_q, nz_q;
  logic [LVL_W-1:0]          lvl_q;
  logic [SIDE_W-1:0]         qx_q, qz_q;
  logic                      oorx_q, oorz_q;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Shared multiplier: operands steered by the sequencer.
  logic signed [RISE_W-1:0] mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    mul_a = srise_q;
    mul_b = OPB_W'(dx_q);
    case (state_q)
      S_PRE0: begin
        mul_a = RISE_W'(cx_q);
        mul_b = {1'b0, absdy_q};
      end
      S_PRE1: begin
        mul_a = RISE_W'(cz_q);
        mul_b = {1'b0, absdy_q};
      end
      S_LV1:   mul_b = OPB_W'(dz_q);
      default: ;
    endcase
  end

  hrp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Shared divider for both coordinates.
  div_ctl_t div_ctl;
  div_sts_t div_sts;

  always_comb begin
    div_ctl.start    = (state_q == S_LV2) || (state_q == S_DIVX && div_sts.done);
    div_ctl.dividend = (state_q == S_LV2) ? nx_q : nz_q;
    div_ctl.divisor  = {absdy_q, 16'b0};
  end

  hrp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .sts_o  (div_sts)
  );

  // Heightmap store.
  logic       ram_we;
  logic [7:0] ram_rdata;

  assign ram_we = accept && (op_e'(s_axis_tuser) == OP_LOAD);

  hrp_ram #(
    .DATA_W (8),
    .DEPTH  (MAX_SIDE * MAX_SIDE)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({in_tz, in_tx}),
    .wdata_i (in_lvl),
    .raddr_i ({qz_q, qx_q}),
    .rdata_o (ram_rdata)
  );

  // Tile test on the read data.
  logic in_map, lvl_match;
  assign in_map = !oorx_q && !oorz_q && ({1'b0, qx_q} < w_eff) && ({1'b0, qz_q} < h_eff);
  assign lvl_match = (ram_rdata == 8'(lvl_q));

  // Working result, and the output word register that holds it while it waits.
  logic                  res_hit_q, res_hit_d;
  logic [SIDE_W-1:0]     res_x_q, res_x_d, res_z_q, res_z_d;
  logic [LVL_W-1:0]      res_lvl_q, res_lvl_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_load;

  // Hand the finished pick to the output register once it is free.
  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  logic signed [RISE_W-1:0] top_plane;
  assign top_plane = RISE_W'(TOP_LEVEL * PLANE_STEP);

  always_comb begin
    state_d     = state_q;
    srise_d     = srise_q;
    res_hit_d   = res_hit_q;
    res_x_d     = res_x_q;
    res_z_d     = res_z_q;
    res_lvl_d   = res_lvl_q;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept && op_e'(s_axis_tuser) == OP_PICK) begin
          state_d = S_PRE0;
        end
      end
      S_PRE0: begin
        res_hit_d = 1'b0;
        res_x_d   = '0;
        res_z_d   = '0;
        res_lvl_d = '0;
        if (absdy_q == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_PRE1;
        end
      end
      S_PRE1: state_d = S_PRE2;
      S_PRE2: state_d = S_LV0;
      S_LV0:  state_d = S_LV1;
      S_LV1:  state_d = S_LV2;
      S_LV2:  state_d = S_DIVX;
      S_DIVX: begin
        if (div_sts.done) begin
          state_d = S_DIVZ;
        end
      end
      S_DIVZ: begin
        if (div_sts.done) begin
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (in_map && lvl_match) begin
          res_hit_d = 1'b1;
          res_x_d   = qx_q;
          res_z_d   = qz_q;
          res_lvl_d = lvl_q;
          state_d   = S_FIN;
        end else if (lvl_q == '0) begin
          state_d = S_FIN;
        end else begin
          // Step down one plane.
          srise_d = dyneg_q ? (srise_q + RISE_W'(PLANE_STEP))
                            : (srise_q - RISE_W'(PLANE_STEP));
          state_d = S_LV0;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_hit_q <= res_hit_d;
    res_x_q   <= res_x_d;
    res_z_q   <= res_z_d;
    res_lvl_q <= res_lvl_d;
    if (out_load) begin
      out_data_q <= {6'b0, res_lvl_q, res_z_q, res_x_q, res_hit_q};
    end
    if (accept) begin
      cx_q    <= in_cx;
      cz_q    <= in_cz;
      dx_q    <= in_dx;
      dz_q    <= in_dz;
      dyneg_q <= in_dy[DIR_W-1];
      absdy_q <= in_dy[DIR_W-1] ? (DIR_W'(0) - DIR_W'(in_dy)) : DIR_W'(in_dy);
      lvl_q   <= LVL_W'(TOP_LEVEL);
      // Rise to the top plane, negated when dy is negative.
      srise_q <= in_dy[DIR_W-1] ? (RISE_W'(in_cy) - top_plane)
                                : (top_plane - RISE_W'(in_cy));
    end else if (state_q == S_PRE0) begin
      srise_q <= srise_q;
    end else begin
      srise_q <= srise_d;
    end
    if (state_q == S_PRE1) begin
      accx_q <= prod;
    end
    if (state_q == S_PRE2) begin
      accz_q <= prod;
    end
    if (state_q == S_LV1) begin
      nx_q <= NUM_W'(accx_q) + NUM_W'(prod);
    end
    if (state_q == S_LV2) begin
      nz_q <= NUM_W'(accz_q) + NUM_W'(prod);
    end
    if (state_q == S_DIVX && div_sts.done) begin
      qx_q   <= div_sts.quotient;
      oorx_q <= div_sts.out_of_range;
    end
    if (state_q == S_DIVZ && div_sts.done) begin
      qz_q   <= div_sts.quotient;
      oorz_q <= div_sts.out_of_range;
    end
    if (state_q == S_CMP && !(in_map && lvl_match) && lvl_q != '0) begin
      lvl_q <= lvl_q - 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: rtl/core/hrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hrp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/hrp_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_mul (
  input  logic                                clk_i,
  input  logic signed [hrp_pkg::RISE_W-1:0]   a_i,
  input  logic signed [hrp_pkg::OPB_W-1:0]    b_i,
  output logic signed [hrp_pkg::PROD_W-1:0]   prod_o
);
  import hrp_pkg::*;

  logic signed [PROD_W-1:0] prod_d;

  assign prod_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule

// File: rtl/core/hrp_div.sv
// Restoring divider, one quotient bit per cycle, for tile coordinates.
// Depends on hrp_pkg.
`timescale 1ns / 1ps

module hrp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hrp_pkg::div_ctl_t   ctl_i,
  output hrp_pkg::div_sts_t   sts_o
);
  import hrp_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    neg_q, neg_d;
  logic [STEP_W-1:0]       k_q, k_d;
  logic [NUM_W-1:0]        rem_q, rem_d;
  logic [QUO_W-1:0]        quo_q, quo_d;
  logic [DEN_W-1:0]        den_q, den_d;
  logic [NUM_W-1:0]        shifted;
  logic [NUM_W:0]          trial;

  assign shifted = NUM_W'(den_q) << k_q;
  assign trial   = {1'b0, rem_q} - {1'b0, shifted};

  always_comb begin
    busy_d = busy_q;
    done_d = busy_q && (k_q == '0);
    neg_d  = neg_q;
    k_d    = k_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (ctl_i.start && !busy_q) begin
      busy_d = 1'b1;
      neg_d  = ctl_i.dividend[NUM_W-1];
      rem_d  = ctl_i.dividend;
      den_d  = ctl_i.divisor;
      quo_d  = '0;
      k_d    = STEP_W'(QUO_W - 1);
    end else if (busy_q) begin
      if (!trial[NUM_W]) begin
        rem_d     = trial[NUM_W-1:0];
        quo_d[k_q] = 1'b1;
      end
      if (k_q == '0) begin
        busy_d = 1'b0;
      end else begin
        k_d = k_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    k_q   <= k_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign sts_o.done         = done_q;
  assign sts_o.out_of_range = neg_q | quo_q[QUO_W-1];
  assign sts_o.quotient     = quo_q[SIDE_W-1:0];

endmodule
